// File: hw/rtl/smc_pkg.sv
// shared types, constants and fixed-point helpers for the stereo mastering chain
package smc_pkg;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} smc_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
	} smc_out_t;

	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 24;
	localparam logic [CfgIdxW-1:0] REG_LOW_ALPHA = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HIGH_ALPHA = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_BYPASS = 2'd2;

	localparam logic [23:0] LOW_ALPHA_RST = 24'd838847;
	localparam logic [23:0] HIGH_ALPHA_RST = 24'd11707829;

	// unsigned coefficients, 24 fraction bits
	localparam logic [24:0] K_POLE = 25'd16693330;
	localparam logic [24:0] K_LOW = 25'd754975;
	localparam logic [24:0] K_HIGH = 25'd838861;
	localparam logic [24:0] K_HALF = 25'd8388608;
	localparam logic [24:0] K_SIDE = 25'd8682209;
	localparam logic [24:0] K_GAIN = 25'd17951621;
	localparam logic [24:0] K_KNEE = 25'd1426063;

	localparam int Sfrac = 27;
	localparam logic [26:0] S_CLIP = 27'd132204462;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh07FFFFFFF) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sh080000000) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// (a * k) >> 24, rounded half away from zero, saturated to 32 bits
	function automatic logic signed [31:0] mulq(input logic signed [33:0] a,
		input logic [24:0] k);
		logic [33:0] mag;
		logic [58:0] p;
		logic [34:0] r;
		logic signed [31:0] res;
		mag = a[33] ? (~$unsigned(a)) + 34'd1 : $unsigned(a);
		p = 59'(mag) * 59'(k);
		r = 35'((p + 59'd8388608) >> 24);
		if (!a[33]) begin
			res = (r >= 35'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(r[31:0]);
		end else begin
			res = (r >= 35'h080000000) ? 32'sh80000000 : $signed(~r[31:0] + 32'd1);
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/stereo_mastering_chain_top.sv
// stereo mastering chain: dc blocker, shelf eq, widener, soft clip on one shared multiplier
// in bypass a pair goes straight to the output stage; otherwise the 27-step restoring
// divider of the soft peak curve, run once per channel, dominates the time from input
// transfer to output valid, and a channel above the knee limit skips it
// one pair in flight at a time; a finished pair waits in ST_PUSH while the output stalls
// arst_n clears the filter state, the sequencer and the config registers to their defaults
module stereo_mastering_chain_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  smc_pkg::smc_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output smc_pkg::smc_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [smc_pkg::CfgIdxW-1:0]    cfg_addr,
	input  logic [smc_pkg::CfgDataW-1:0]   cfg_data
);
	import smc_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_POLE = 5'd1;
	localparam logic [4:0] ST_DC   = 5'd2;
	localparam logic [4:0] ST_LB   = 5'd3;
	localparam logic [4:0] ST_LBW  = 5'd4;
	localparam logic [4:0] ST_HLW  = 5'd5;
	localparam logic [4:0] ST_Y1   = 5'd6;
	localparam logic [4:0] ST_Y2   = 5'd7;
	localparam logic [4:0] ST_MID  = 5'd8;
	localparam logic [4:0] ST_SIDE = 5'd9;
	localparam logic [4:0] ST_MS   = 5'd10;
	localparam logic [4:0] ST_GAIN = 5'd11;
	localparam logic [4:0] ST_KNEE = 5'd12;
	localparam logic [4:0] ST_DIVI = 5'd13;
	localparam logic [4:0] ST_DIV  = 5'd14;
	localparam logic [4:0] ST_RND  = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;
	localparam logic [4:0] ST_PUSH = 5'd17;

	logic [4:0] state_q;
	logic [23:0] low_alpha_q, high_alpha_q;
	logic bypass_q;

	logic signed [31:0] dpi_q [2];
	logic signed [31:0] dpo_q [2];
	logic signed [31:0] lb_q [2];
	logic signed [31:0] hl_q [2];

	smc_in_t in_q;
	logic ch_q, oc_q;
	logic signed [31:0] dc_q, l_q, r_q, mid_q, v0_q, v1_q;
	logic signed [33:0] acc_q;
	logic signed [31:0] mul_q;
	logic [31:0] n_q;
	logic sign_q;
	logic [28:0] d_q;
	logic [29:0] rem_q;
	logic [28:0] quo_q;
	logic [4:0] cnt_q;
	logic [26:0] res_q;
	logic signed [15:0] res_l_q, res_r_q;
	logic out_valid_q;
	smc_out_t out_q;

	logic signed [33:0] mul_a;
	logic [24:0] mul_k;
	logic signed [31:0] x_c, dc_c, y_c, lbn_c, hln_c;
	logic [31:0] n_c;
	logic [28:0] d_c;
	logic [29:0] r2_c;
	logic ge_c;
	logic [28:0] qr_c;
	logic [42:0] t_c;
	logic [15:0] m_c;
	logic signed [15:0] s16_c;
	logic push;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign push = (state_q == ST_PUSH) && (!out_valid_q || out_ready);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_k = '0;
		unique case (state_q)
			ST_POLE: begin
				mul_a = 34'(dpo_q[ch_q]);
				mul_k = K_POLE;
			end
			ST_LB: begin
				mul_a = 34'(dc_q) - 34'(lb_q[ch_q]);
				mul_k = 25'(low_alpha_q);
			end
			ST_LBW: begin
				mul_a = 34'(dc_q) - 34'(hl_q[ch_q]);
				mul_k = 25'(high_alpha_q);
			end
			ST_HLW: begin
				mul_a = 34'(lb_q[ch_q]);
				mul_k = K_LOW;
			end
			ST_Y1: begin
				mul_a = 34'(dc_q) - 34'(hl_q[ch_q]);
				mul_k = K_HIGH;
			end
			ST_MID: begin
				mul_a = 34'(l_q) + 34'(r_q);
				mul_k = K_HALF;
			end
			ST_SIDE: begin
				mul_a = 34'(l_q) - 34'(r_q);
				mul_k = K_SIDE;
			end
			ST_GAIN: begin
				mul_a = oc_q ? 34'(v1_q) : 34'(v0_q);
				mul_k = K_GAIN;
			end
			ST_KNEE: begin
				mul_a = $signed({2'b00, n_c});
				mul_k = K_KNEE;
			end
			default: begin
				mul_a = '0;
				mul_k = '0;
			end
		endcase
	end

	always_comb begin
		x_c = ch_q ? 32'({in_q.right_in, 12'b0}) : 32'({in_q.left_in, 12'b0});
		x_c = $signed(ch_q ? {{4{in_q.right_in[15]}}, in_q.right_in, 12'b0}
			: {{4{in_q.left_in[15]}}, in_q.left_in, 12'b0});
		dc_c = sat32(36'(x_c) - 36'(dpi_q[ch_q]) + 36'(mul_q));
		lbn_c = sat32(36'(lb_q[ch_q]) + 36'(mul_q));
		hln_c = sat32(36'(hl_q[ch_q]) + 36'(mul_q));
		y_c = sat32(36'(acc_q) + 36'(mul_q));
		n_c = mul_q[31] ? (~$unsigned(mul_q)) + 32'd1 : $unsigned(mul_q);
		d_c = 29'd134217728 + mul_q[28:0];
		r2_c = {rem_q[28:0], 1'b0};
		ge_c = r2_c >= {1'b0, d_q};
		qr_c = quo_q + 29'(ge_c);
		// scale by 32767 as a shift and subtract, round half up on magnitude
		t_c = ({16'b0, res_q} << 15) - 43'(res_q) + 43'd67108864;
		m_c = t_c[42:27];
		if (m_c > 16'd32767) begin
			m_c = 16'd32767;
		end
		s16_c = sign_q ? $signed(~m_c + 16'd1) : $signed(m_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_alpha_q <= LOW_ALPHA_RST;
			high_alpha_q <= HIGH_ALPHA_RST;
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOW_ALPHA: low_alpha_q <= cfg_data;
				REG_HIGH_ALPHA: high_alpha_q <= cfg_data;
				REG_BYPASS: bypass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			ch_q <= 1'b0;
			oc_q <= 1'b0;
			cnt_q <= '0;
			for (int i = 0; i < 2; i++) begin
				dpi_q[i] <= '0;
				dpo_q[i] <= '0;
				lb_q[i] <= '0;
				hl_q[i] <= '0;
			end
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ch_q <= 1'b0;
						oc_q <= 1'b0;
						state_q <= bypass_q ? ST_PUSH : ST_POLE;
					end
				end
				ST_POLE: state_q <= ST_DC;
				ST_DC: begin
					dpi_q[ch_q] <= x_c;
					dpo_q[ch_q] <= dc_c;
					state_q <= ST_LB;
				end
				ST_LB: state_q <= ST_LBW;
				ST_LBW: begin
					lb_q[ch_q] <= lbn_c;
					state_q <= ST_HLW;
				end
				ST_HLW: begin
					hl_q[ch_q] <= hln_c;
					state_q <= ST_Y1;
				end
				ST_Y1: state_q <= ST_Y2;
				ST_Y2: begin
					ch_q <= 1'b1;
					state_q <= ch_q ? ST_MID : ST_POLE;
				end
				ST_MID: state_q <= ST_SIDE;
				ST_SIDE: state_q <= ST_MS;
				ST_MS: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_KNEE;
				ST_KNEE: state_q <= ST_DIVI;
				ST_DIVI: begin
					cnt_q <= 5'(Sfrac);
					state_q <= (n_q[31:28] != 4'd0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: state_q <= ST_OUT;
				ST_OUT: begin
					oc_q <= 1'b1;
					state_q <= oc_q ? ST_PUSH : ST_GAIN;
				end
				ST_PUSH: begin
					if (push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mulq(mul_a, mul_k);
		if (in_valid && in_ready) begin
			in_q <= in_data;
			res_l_q <= in_data.left_in;
			res_r_q <= in_data.right_in;
		end
		case (state_q)
			ST_DC: dc_q <= dc_c;
			ST_Y1: acc_q <= 34'(dc_q) + 34'(mul_q);
			ST_Y2: begin
				if (ch_q) begin
					r_q <= y_c;
				end else begin
					l_q <= y_c;
				end
			end
			ST_SIDE: mid_q <= mul_q;
			ST_MS: begin
				v0_q <= sat32(36'(mid_q) + 36'(mul_q));
				v1_q <= sat32(36'(mid_q) - 36'(mul_q));
			end
			ST_KNEE: begin
				n_q <= n_c;
				sign_q <= mul_q[31];
			end
			ST_DIVI: begin
				d_q <= d_c;
				res_q <= S_CLIP;
				if ({1'b0, n_q[27:0]} >= d_c) begin
					quo_q <= 29'd1;
					rem_q <= 30'({1'b0, n_q[27:0]} - d_c);
				end else begin
					quo_q <= 29'd0;
					rem_q <= 30'(n_q[27:0]);
				end
			end
			ST_DIV: begin
				quo_q <= {quo_q[27:0], ge_c};
				rem_q <= ge_c ? r2_c - {1'b0, d_q} : r2_c;
			end
			ST_RND: res_q <= (qr_c > 29'(S_CLIP)) ? S_CLIP : qr_c[26:0];
			ST_OUT: begin
				if (oc_q) begin
					res_r_q <= s16_c;
				end else begin
					res_l_q <= s16_c;
				end
			end
			default: ;
		endcase
		if (push) begin
			out_q.left_out <= res_l_q;
			out_q.right_out <= res_r_q;
		end
	end

	// a pair in bypass goes straight to the output stage
	a_bypass_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && bypass_q |=> state_q == ST_PUSH)
		else $error("bypass transfer did not go to output stage");

	// a finished pair is held while the output register is full and stalled
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH && out_valid_q && !out_ready |=> state_q == ST_PUSH)
		else $error("finished pair dropped while output stalled");

	// divider counter never runs out inside the iteration state
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != 5'd0)
		else $error("divider counter underflow");

	// the block takes no new pair right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

// File: verif/smc_chain_checker.sv
// checker for the stereo mastering chain: tracks registers, predicts each mastered pair, compares
module smc_chain_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  smc_pkg::smc_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  smc_pkg::smc_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [smc_pkg::CfgIdxW-1:0]   cfg_addr,
	input  logic [smc_pkg::CfgDataW-1:0]  cfg_data,
	output int                            fail_count,
	output int                            pairs_pending,
	output int                            pairs_checked
);
	import smc_pkg::*;

	localparam longint unsigned C_POLE = ((64'd995 << 24) + 64'd500) / 64'd1000;
	localparam longint unsigned C_LOW = ((64'd45 << 24) + 64'd500) / 64'd1000;
	localparam longint unsigned C_HIGH = ((64'd50 << 24) + 64'd500) / 64'd1000;
	localparam longint unsigned C_HALF = ((64'd1 << 24) + 64'd1) / 64'd2;
	localparam longint unsigned C_SIDE = ((64'd1035 << 24) + 64'd1000) / 64'd2000;
	localparam longint unsigned C_GAIN = ((64'd107 << 24) + 64'd50) / 64'd100;
	localparam longint unsigned C_KNEE = ((64'd85 << 24) + 64'd500) / 64'd1000;
	localparam int FRAC = 27;
	localparam longint unsigned UNITY = 64'd1 << FRAC;
	localparam longint unsigned CLIP_LVL = ((64'd985 << FRAC) + 64'd500) / 64'd1000;

	longint unsigned low_coef, high_coef;
	logic bypass_on;
	longint prev_in [2];
	longint prev_out [2];
	longint low_lp [2];
	longint high_lp [2];
	smc_out_t expected_pairs[$];

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product with 24 fraction bit coefficient, rounded half away from zero
	function automatic longint coef_mul(input longint a, input longint unsigned k);
		longint unsigned m, r;
		m = (a < 0) ? longint'(-a) : longint'(a);
		r = (m * k + (64'd1 << 23)) >> 24;
		if (r > (64'd1 << 31)) r = 64'd1 << 31;
		return clamp32((a < 0) ? -longint'(r) : longint'(r));
	endfunction

	function automatic longint eq_channel(input longint x, input int c);
		longint dc, y;
		dc = clamp32(x - prev_in[c] + coef_mul(prev_out[c], C_POLE));
		prev_in[c] = x;
		prev_out[c] = dc;
		low_lp[c] = clamp32(low_lp[c] + coef_mul(dc - low_lp[c], low_coef));
		high_lp[c] = clamp32(high_lp[c] + coef_mul(dc - high_lp[c], high_coef));
		y = dc + coef_mul(low_lp[c], C_LOW) + coef_mul(dc - high_lp[c], C_HIGH);
		return clamp32(y);
	endfunction

	function automatic longint peak_curve(input longint v);
		longint y;
		longint unsigned n, d, q, r, res;
		y = coef_mul(v, C_GAIN);
		n = (y < 0) ? longint'(-y) : longint'(y);
		if (n >= 2 * UNITY) begin
			res = CLIP_LVL;
		end else begin
			d = UNITY + longint'(coef_mul(longint'(n), C_KNEE));
			q = n / d;
			r = n % d;
			for (int i = 0; i < FRAC; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q = q | 1;
				end
			end
			if ((r << 1) >= d) q = q + 1;
			res = (q > CLIP_LVL) ? CLIP_LVL : q;
		end
		return (y < 0) ? -longint'(res) : longint'(res);
	endfunction

	function automatic logic signed [15:0] to_pcm(input longint v);
		longint unsigned m;
		longint o;
		m = (v < 0) ? longint'(-v) : longint'(v);
		if (m > UNITY) m = UNITY;
		m = (m * 32767 + (64'd1 << (FRAC - 1))) >> FRAC;
		if (m > 32767) m = 32767;
		o = (v < 0) ? -longint'(m) : longint'(m);
		return o[15:0];
	endfunction

	function automatic smc_out_t master_pair(input smc_in_t s);
		smc_out_t o;
		longint l, r, mid, side;
		if (bypass_on) begin
			o.left_out = s.left_in;
			o.right_out = s.right_in;
			return o;
		end
		l = eq_channel(longint'(s.left_in) * 4096, 0);
		r = eq_channel(longint'(s.right_in) * 4096, 1);
		mid = coef_mul(l + r, C_HALF);
		side = coef_mul(l - r, C_SIDE);
		o.left_out = to_pcm(peak_curve(clamp32(mid + side)));
		o.right_out = to_pcm(peak_curve(clamp32(mid - side)));
		return o;
	endfunction

	task automatic report(input string what, input logic signed [15:0] got,
		input logic signed [15:0] want);
		$display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pairs_checked = 0;
		pairs_pending = 0;
		low_coef = 838847;
		high_coef = 11707829;
		bypass_on = 1'b0;
		for (int c = 0; c < 2; c++) begin
			prev_in[c] = 0;
			prev_out[c] = 0;
			low_lp[c] = 0;
			high_lp[c] = 0;
		end
	end

	always @(posedge clk) begin
		smc_out_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_LOW_ALPHA: low_coef = cfg_data;
					REG_HIGH_ALPHA: high_coef = cfg_data;
					REG_BYPASS: bypass_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_pairs.push_back(master_pair(in_data));
			if (out_valid && out_ready) begin
				if (expected_pairs.size() == 0) begin
					$display("unexpected output transfer at %0t", $realtime);
					fail_count++;
				end else begin
					want = expected_pairs.pop_front();
					pairs_checked++;
					if (out_data.left_out !== want.left_out)
						report("left_out", out_data.left_out, want.left_out);
					if (out_data.right_out !== want.right_out)
						report("right_out", out_data.right_out, want.right_out);
				end
			end
			pairs_pending = expected_pairs.size();
		end
	end

endmodule

// File: verif/stereo_mastering_chain_top_test.sv
// testbench top for the stereo mastering chain: stimulus, register phases and verdict
module stereo_mastering_chain_top_test;
	import smc_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	smc_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	smc_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic no_gaps = 1'b0;
	int fail_count, pairs_pending, pairs_checked;
	int pairs_sent = 0;

	always #2 clk = ~clk;

	stereo_mastering_chain_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	smc_chain_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.fail_count(fail_count), .pairs_pending(pairs_pending),
		.pairs_checked(pairs_checked)
	);

	task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		repeat (gap) @(negedge clk);
		in_data.left_in = l;
		in_data.right_in = r;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample(input int mode);
		case (mode)
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return 16'($signed($urandom_range(0, 1000)) - 500);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			if ((i % 40) == 0) no_gaps = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 5);
			send_pair(pick_sample(mode), pick_sample(mode > 1 ? $urandom_range(0, 5) : mode));
		end
		no_gaps = 1'b0;
	endtask

	// all results back and the pipeline drained before touching the registers
	task automatic drain();
		while (pairs_pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// receiver stalls a random number of cycles before each transfer
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 13);
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#3000000;
		$display("[stereo_mastering_chain_top] ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: full scale steps, opposing channels, silence, alternation
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh8000, 16'sh7FFF);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh0001, 16'shFFFF);
		for (int i = 0; i < 6; i++)
			send_pair(i[0] ? 16'sh7FFF : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7FFF);
		send_pair(16'sh5555, 16'shAAAA);
		drain();

		// bypass passes samples through and freezes the filters
		write_reg(REG_BYPASS, 24'd1);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh1234, 16'shEDCB);
		send_pair(16'sh0000, 16'shFFFF);
		drain();
		write_reg(REG_BYPASS, 24'd0);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_pair(16'sh4000, 16'shC000);
		send_random(120);

		// coefficient extremes
		drain();
		write_reg(REG_LOW_ALPHA, 24'd0);
		write_reg(REG_HIGH_ALPHA, 24'hFFFFFF);
		send_random(90);
		drain();
		write_reg(REG_LOW_ALPHA, 24'hFFFFFF);
		write_reg(REG_HIGH_ALPHA, 24'd0);
		send_random(90);
		drain();
		write_reg(REG_BYPASS, 24'hFFFFFF);
		send_random(40);
		drain();
		write_reg(REG_BYPASS, 24'd0);
		write_reg(REG_LOW_ALPHA, 24'($urandom));
		write_reg(REG_HIGH_ALPHA, 24'($urandom));
		send_random(100);
		drain();
		write_reg(REG_LOW_ALPHA, LOW_ALPHA_RST);
		write_reg(REG_HIGH_ALPHA, HIGH_ALPHA_RST);
		send_random(90);

		drain();
		$display("sent %0d stereo pairs, checked %0d mastered pairs", pairs_sent, pairs_checked);
		$display("covered bypass, default and extreme filter coefficients, full-scale steps");
		if (fail_count == 0) begin
			$display("[stereo_mastering_chain_top] OK");
		end else begin
			$display("[stereo_mastering_chain_top] ERROR");
		end
		$finish;
	end

endmodule
